// ----- design/acs_pkg.sv -----
// acs_pkg: shared types and constants for the affinity chunk scheduler.
// No dependencies; compiled first.
package acs_pkg;

  localparam int OP_W       = 1;
  localparam int WORKER_W   = 6;
  localparam int FIELD_W    = 16;
  localparam int CFG_NW_W   = 7;
  localparam int CFG_TOT_W  = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_BEGIN   = 1'b0;
  localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_NUM_WORKERS = 1'b0;
  localparam logic REG_TOTAL_ITERS = 1'b1;

  localparam logic [CFG_NW_W-1:0]  NUM_WORKERS_RESET = 7'd4;
  localparam logic [CFG_TOT_W-1:0] TOTAL_ITERS_RESET = 16'd729;

  // control travelling with the token along the cell row
  typedef struct packed {
    logic valid;
    logic part;   // 1: partition pass, 0: scan pass
  } tok_ctl_t;

endpackage

// ----- design/acs_in_if.sv -----
// acs_in_if: request channel (operation, worker) with valid/ready.
// Depends on acs_pkg.
interface acs_in_if import acs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [WORKER_W-1:0] worker;

  modport source (output valid, output operation, output worker, input ready);
  modport sink   (input valid, input operation, input worker, output ready);
endinterface

// ----- design/acs_out_if.sv -----
// acs_out_if: grant channel (chunk fields, owner, all_done) with valid/ready.
// Depends on acs_pkg.
interface acs_out_if import acs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  chunk_start;
  logic [FIELD_W-1:0]  chunk_length;
  logic [WORKER_W-1:0] owner;
  logic [FIELD_W-1:0]  owner_remaining_before;
  logic                all_done;

  modport source (output valid, output chunk_start, output chunk_length, output owner,
                  output owner_remaining_before, output all_done, input ready);
  modport sink   (input valid, input chunk_start, input chunk_length, input owner,
                  input owner_remaining_before, input all_done, output ready);
endinterface

// ----- design/acs_divider.sv -----
// acs_divider: restoring divider, one quotient bit per cycle, ceiling result.
// No package dependencies.
module acs_divider #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 7,
  localparam int CntW      = $clog2(DIVIDEND_W)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVISOR_W-1:0]  r_q, d_q, r_d;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  ge;

  always_comb begin
    trial = {r_q, dvd_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
    r_d   = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DIVIDEND_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      r_q   <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIVIDEND_W-2:0], ge};
      r_q   <= r_d;
    end
  end

  // round up when a remainder is left
  assign quot_o = dvd_q + DIVIDEND_W'(r_q != '0);
  assign done_o = done_q;

endmodule

// ----- design/acs_cell.sv -----
// acs_cell: one worker's block state plus one stage of the token row.
// Depends on acs_pkg.
module acs_cell import acs_pkg::*; #(
  parameter int MAX_WORKERS = 64,
  parameter int ITER_WIDTH  = 16,
  parameter int IDX         = 0,
  localparam int IdxW       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
  localparam int NwW        = $clog2(MAX_WORKERS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [NwW-1:0]        nw_i,
  input  logic [ITER_WIDTH-1:0] ipt_i,
  input  logic [ITER_WIDTH-1:0] tot_i,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  logic [ITER_WIDTH-1:0] wr_rem_i,
  input  tok_ctl_t              ctl_i,
  input  logic [WORKER_W-1:0]   worker_i,
  input  logic [ITER_WIDTH-1:0] own_rem_i,
  input  logic [ITER_WIDTH-1:0] own_end_i,
  input  logic [IdxW-1:0]       own_idx_i,
  input  logic [ITER_WIDTH-1:0] best_rem_i,
  input  logic [ITER_WIDTH-1:0] best_end_i,
  input  logic [IdxW-1:0]       best_idx_i,
  input  logic [ITER_WIDTH-1:0] lo_i,
  output tok_ctl_t              ctl_o,
  output logic [WORKER_W-1:0]   worker_o,
  output logic [ITER_WIDTH-1:0] own_rem_o,
  output logic [ITER_WIDTH-1:0] own_end_o,
  output logic [IdxW-1:0]       own_idx_o,
  output logic [ITER_WIDTH-1:0] best_rem_o,
  output logic [ITER_WIDTH-1:0] best_end_o,
  output logic [IdxW-1:0]       best_idx_o,
  output logic [ITER_WIDTH-1:0] lo_o
);

  logic [ITER_WIDTH-1:0] rem_q, rem_d, end_q, end_d;
  tok_ctl_t              ctl_q;
  logic [WORKER_W-1:0]   worker_q;
  logic [ITER_WIDTH-1:0] own_rem_q, own_rem_d, own_end_q, own_end_d;
  logic [IdxW-1:0]       own_idx_q, own_idx_d, best_idx_q, best_idx_d;
  logic [ITER_WIDTH-1:0] best_rem_q, best_rem_d, best_end_q, best_end_d;
  logic [ITER_WIDTH-1:0] lo_q, lo_d, hi;
  logic [ITER_WIDTH:0]   sum;
  logic                  active, match;

  always_comb begin
    active = NwW'(IDX) < nw_i;
    // requester maps here when worker mod MAX_WORKERS equals this index
    match = 1'b0;
    for (int k = 0; k < 2**WORKER_W; k++) begin
      if (IDX + k * MAX_WORKERS < 2**WORKER_W) begin
        match = match | (worker_i == WORKER_W'(IDX + k * MAX_WORKERS));
      end
    end
    sum = {1'b0, lo_i} + {1'b0, ipt_i};
    hi  = (sum > {1'b0, tot_i}) ? tot_i : sum[ITER_WIDTH-1:0];

    rem_d      = rem_q;
    end_d      = end_q;
    own_rem_d  = own_rem_i;
    own_end_d  = own_end_i;
    own_idx_d  = own_idx_i;
    best_rem_d = best_rem_i;
    best_end_d = best_end_i;
    best_idx_d = best_idx_i;
    lo_d       = lo_i;

    if (ctl_i.valid && ctl_i.part) begin
      if (active) begin
        rem_d = hi - lo_i;
        end_d = hi;
        lo_d  = hi;
      end else begin
        rem_d = '0;
        end_d = '0;
      end
    end else if (ctl_i.valid) begin
      if (match && rem_q != '0) begin
        own_rem_d = rem_q;
        own_end_d = end_q;
        own_idx_d = IdxW'(IDX);
      end
      // strict compare keeps the lowest index on ties
      if (active && rem_q > best_rem_i) begin
        best_rem_d = rem_q;
        best_end_d = end_q;
        best_idx_d = IdxW'(IDX);
      end
    end

    if (wr_en_i && wr_idx_i == IdxW'(IDX)) begin
      rem_d = wr_rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      end_q <= '0;
      ctl_q <= '0;
    end else begin
      rem_q <= rem_d;
      end_q <= end_d;
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    worker_q   <= worker_i;
    own_rem_q  <= own_rem_d;
    own_end_q  <= own_end_d;
    own_idx_q  <= own_idx_d;
    best_rem_q <= best_rem_d;
    best_end_q <= best_end_d;
    best_idx_q <= best_idx_d;
    lo_q       <= lo_d;
  end

  assign ctl_o      = ctl_q;
  assign worker_o   = worker_q;
  assign own_rem_o  = own_rem_q;
  assign own_end_o  = own_end_q;
  assign own_idx_o  = own_idx_q;
  assign best_rem_o = best_rem_q;
  assign best_end_o = best_end_q;
  assign best_idx_o = best_idx_q;
  assign lo_o       = lo_q;

endmodule

// ----- design/affinity_chunk_scheduler.sv -----
// affinity_chunk_scheduler: top level, row of worker cells, shared divider, APB regs.
// Depends on acs_pkg, acs_in_if, acs_out_if, acs_cell, acs_divider.
//
//   channel  dir  handshake            beat contents
//   in_i     in   valid/ready          operation, worker
//   res_o    out  valid/ready          chunk_start, chunk_length, owner,
//                                      owner_remaining_before, all_done
//   apb      in   psel/penable/pready  paddr, pwdata -> prdata
//
// Sequencing: one beat at a time. A begin runs a ceiling divide for the block
//   size, then the partition token walks the cell row. A request sends the scan
//   token through the row, then, if a chunk is found, divides for the chunk length.
// Reset: asynchronous, clears all worker counts and block ends at once.
// Stalls: the result sits in an output register; in_i is ready again as soon
//   as it is written there, and a later result waits until res_o drains.
module affinity_chunk_scheduler import acs_pkg::*; #(
  parameter int MAX_WORKERS = 64,
  parameter int ITER_WIDTH  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  acs_in_if.sink                in_i,
  acs_out_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IdxW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NwW  = $clog2(MAX_WORKERS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PDIV = 6'b000010,  // block size divide
    S_PART = 6'b000100,  // partition token in flight
    S_SCAN = 6'b001000,  // scan token in flight
    S_LDIV = 6'b010000,  // chunk length divide
    S_DONE = 6'b100000   // hand result to output register
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration ----------------
  logic [CFG_NW_W-1:0]  cfg_nw_q;
  logic [CFG_TOT_W-1:0] cfg_tot_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nw_q  <= NUM_WORKERS_RESET;
      cfg_tot_q <= TOTAL_ITERS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_WORKERS: cfg_nw_q  <= pwdata[CFG_NW_W-1:0];
        REG_TOTAL_ITERS: cfg_tot_q <= pwdata[CFG_TOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_WORKERS: prdata = APB_DATA_W'(cfg_nw_q);
      REG_TOTAL_ITERS: prdata = APB_DATA_W'(cfg_tot_q);
      default:         prdata = '0;
    endcase
  end

  // effective worker count: zero acts as one, clamp at MAX_WORKERS
  logic [NwW-1:0]        nw_eff;
  logic [ITER_WIDTH-1:0] tot_w;

  always_comb begin
    if (cfg_nw_q == '0) begin
      nw_eff = NwW'(1);
    end else if ({2'b00, cfg_nw_q} > 9'(MAX_WORKERS)) begin
      nw_eff = NwW'(MAX_WORKERS);
    end else begin
      nw_eff = NwW'(cfg_nw_q);
    end
  end

  assign tot_w = ITER_WIDTH'(cfg_tot_q);

  // ---------------- cell row ----------------
  tok_ctl_t              ch_ctl      [MAX_WORKERS+1];
  logic [WORKER_W-1:0]   ch_worker   [MAX_WORKERS+1];
  logic [ITER_WIDTH-1:0] ch_own_rem  [MAX_WORKERS+1];
  logic [ITER_WIDTH-1:0] ch_own_end  [MAX_WORKERS+1];
  logic [IdxW-1:0]       ch_own_idx  [MAX_WORKERS+1];
  logic [ITER_WIDTH-1:0] ch_best_rem [MAX_WORKERS+1];
  logic [ITER_WIDTH-1:0] ch_best_end [MAX_WORKERS+1];
  logic [IdxW-1:0]       ch_best_idx [MAX_WORKERS+1];
  logic [ITER_WIDTH-1:0] ch_lo       [MAX_WORKERS+1];

  tok_ctl_t              inj_ctl_q, inj_ctl_d;
  logic [WORKER_W-1:0]   inj_worker_q;
  logic [ITER_WIDTH-1:0] ipt_q;

  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  logic [ITER_WIDTH-1:0] wr_rem;

  // fresh token enters cell 0 with empty accumulators
  assign ch_ctl[0]      = inj_ctl_q;
  assign ch_worker[0]   = inj_worker_q;
  assign ch_own_rem[0]  = '0;
  assign ch_own_end[0]  = '0;
  assign ch_own_idx[0]  = '0;
  assign ch_best_rem[0] = '0;
  assign ch_best_end[0] = '0;
  assign ch_best_idx[0] = '0;
  assign ch_lo[0]       = '0;

  for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
    acs_cell #(
      .MAX_WORKERS (MAX_WORKERS),
      .ITER_WIDTH  (ITER_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .nw_i       (nw_eff),
      .ipt_i      (ipt_q),
      .tot_i      (tot_w),
      .wr_en_i    (wr_en),
      .wr_idx_i   (wr_idx),
      .wr_rem_i   (wr_rem),
      .ctl_i      (ch_ctl[g]),
      .worker_i   (ch_worker[g]),
      .own_rem_i  (ch_own_rem[g]),
      .own_end_i  (ch_own_end[g]),
      .own_idx_i  (ch_own_idx[g]),
      .best_rem_i (ch_best_rem[g]),
      .best_end_i (ch_best_end[g]),
      .best_idx_i (ch_best_idx[g]),
      .lo_i       (ch_lo[g]),
      .ctl_o      (ch_ctl[g+1]),
      .worker_o   (ch_worker[g+1]),
      .own_rem_o  (ch_own_rem[g+1]),
      .own_end_o  (ch_own_end[g+1]),
      .own_idx_o  (ch_own_idx[g+1]),
      .best_rem_o (ch_best_rem[g+1]),
      .best_end_o (ch_best_end[g+1]),
      .best_idx_o (ch_best_idx[g+1]),
      .lo_o       (ch_lo[g+1])
    );
  end

  // ---------------- scan result at the end of the row ----------------
  logic                  scan_own, scan_found;
  logic [ITER_WIDTH-1:0] scan_rem, scan_end;
  logic [IdxW-1:0]       scan_src;

  always_comb begin
    scan_own   = ch_own_rem[MAX_WORKERS] != '0;
    scan_found = scan_own || (ch_best_rem[MAX_WORKERS] != '0);
    scan_rem   = scan_own ? ch_own_rem[MAX_WORKERS] : ch_best_rem[MAX_WORKERS];
    scan_end   = scan_own ? ch_own_end[MAX_WORKERS] : ch_best_end[MAX_WORKERS];
    scan_src   = scan_own ? ch_own_idx[MAX_WORKERS] : ch_best_idx[MAX_WORKERS];
  end

  // ---------------- shared divider ----------------
  logic                  div_start, div_done;
  logic [ITER_WIDTH-1:0] div_dividend, div_quot;
  logic                  in_accept, tok_out;

  assign in_accept    = in_i.valid && in_i.ready;
  assign tok_out      = ch_ctl[MAX_WORKERS].valid;
  assign div_start    = (in_accept && in_i.operation == OP_BEGIN) ||
                        (state_q == S_SCAN && tok_out && scan_found);
  assign div_dividend = (state_q == S_IDLE) ? tot_w : scan_rem;

  acs_divider #(
    .DIVIDEND_W (ITER_WIDTH),
    .DIVISOR_W  (NwW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (nw_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------- sequencer ----------------
  logic [IdxW-1:0]       gr_src_q;
  logic [ITER_WIDTH-1:0] gr_rem_q, gr_end_q;
  logic [FIELD_W-1:0]    res_start_q, res_len_q, res_before_q;
  logic [WORKER_W-1:0]   res_owner_q;
  logic                  res_done_q;
  logic                  out_valid_q, out_load;

  logic [FIELD_W-1:0]    out_start_q, out_len_q, out_before_q;
  logic [WORKER_W-1:0]   out_owner_q;
  logic                  out_done_q;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  // grant write back to the owning cell
  assign wr_en  = (state_q == S_LDIV) && div_done;
  assign wr_idx = gr_src_q;
  assign wr_rem = gr_rem_q - div_quot;

  always_comb begin
    state_d   = state_q;
    inj_ctl_d = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_i.operation == OP_BEGIN) begin
            state_d = S_PDIV;
          end else begin
            inj_ctl_d = '{valid: 1'b1, part: 1'b0};
            state_d   = S_SCAN;
          end
        end
      end
      S_PDIV: begin
        if (div_done) begin
          inj_ctl_d = '{valid: 1'b1, part: 1'b1};
          state_d   = S_PART;
        end
      end
      S_PART: if (tok_out) state_d = S_DONE;
      S_SCAN: begin
        if (tok_out) state_d = scan_found ? S_LDIV : S_DONE;
      end
      S_LDIV: if (div_done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inj_ctl_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      inj_ctl_q <= inj_ctl_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      inj_worker_q <= in_i.worker;
    end
    if (state_q == S_PDIV && div_done) begin
      ipt_q <= div_quot;
    end
    if (state_q == S_SCAN && tok_out) begin
      gr_src_q <= scan_src;
      gr_rem_q <= scan_rem;
      gr_end_q <= scan_end;
      // nothing left anywhere
      res_start_q  <= '0;
      res_len_q    <= '0;
      res_owner_q  <= '0;
      res_before_q <= '0;
      res_done_q   <= 1'b1;
    end
    if (state_q == S_PART && tok_out) begin
      res_start_q  <= '0;
      res_len_q    <= '0;
      res_owner_q  <= '0;
      res_before_q <= '0;
      res_done_q   <= (tot_w == '0);
    end
    if (wr_en) begin
      res_start_q  <= FIELD_W'(gr_end_q - gr_rem_q);
      res_len_q    <= FIELD_W'(div_quot);
      res_owner_q  <= WORKER_W'(gr_src_q);
      res_before_q <= FIELD_W'(gr_rem_q);
      res_done_q   <= 1'b0;
    end
    if (out_load) begin
      out_start_q  <= res_start_q;
      out_len_q    <= res_len_q;
      out_owner_q  <= res_owner_q;
      out_before_q <= res_before_q;
      out_done_q   <= res_done_q;
    end
  end

  assign in_i.ready                   = (state_q == S_IDLE);
  assign res_o.valid                  = out_valid_q;
  assign res_o.chunk_start            = out_start_q;
  assign res_o.chunk_length           = out_len_q;
  assign res_o.owner                  = out_owner_q;
  assign res_o.owner_remaining_before = out_before_q;
  assign res_o.all_done               = out_done_q;

`ifndef SYNTH
  // a token leaves the row only while the sequencer waits for it
  a_tok_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_out |-> (state_q == S_PART || state_q == S_SCAN))
    else $error("token left cell row outside a pass");

  // the divider finishes only in a divide state
  a_div_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_PDIV || state_q == S_LDIV))
    else $error("divider done outside a divide state");

  // a grant is nonzero and never exceeds the owner's count
  a_grant_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (div_quot != '0 && div_quot <= gr_rem_q))
    else $error("chunk length out of range");

  // a new beat is taken only once the previous result reached the output register
  a_result_handed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not handed to output register");
`endif

endmodule

// ----- tb/sv/affinity_chunk_scheduler_test.sv -----
// affinity_chunk_scheduler_test: self-checking bench for the affinity chunk scheduler.
// Drives begin/request beats and APB register writes, predicts every grant in a small
// scoreboard class. Depends on acs_pkg, acs_in_if, acs_out_if and the scheduler RTL.

import acs_pkg::*;

localparam int WORKER_SLOTS = 64;

typedef struct packed {
  logic [FIELD_W-1:0]  start;
  logic [FIELD_W-1:0]  length;
  logic [WORKER_W-1:0] owner;
  logic [FIELD_W-1:0]  rem_before;
  logic                done;
} grant_t;

// Scoreboard: own copy of the registers and of the per-worker blocks, plus the
// grants still owed by the block in beat order.
class chunk_grant_book;
  logic [CFG_NW_W-1:0]  workers_cfg;
  logic [CFG_TOT_W-1:0] total_cfg;
  logic [FIELD_W-1:0]   left_in_block [WORKER_SLOTS];
  logic [FIELD_W-1:0]   block_stop    [WORKER_SLOTS];
  grant_t               pending_grants[$];
  int                   mismatches;

  function new();
    workers_cfg = NUM_WORKERS_RESET;
    total_cfg   = TOTAL_ITERS_RESET;
    mismatches  = 0;
    foreach (left_in_block[w]) begin
      left_in_block[w] = '0;
      block_stop[w]    = '0;
    end
  endfunction

  // 0 acts as 1, anything above the slot count acts as the slot count
  function int unsigned active_workers();
    if (workers_cfg == 0) return 1;
    if (workers_cfg > WORKER_SLOTS) return WORKER_SLOTS;
    return 32'(workers_cfg);
  endfunction

  // Accepted input beat: update the blocks and queue the grant it must produce.
  function grant_t note_beat(logic [OP_W-1:0] op, logic [WORKER_W-1:0] wk);
    grant_t      g;
    int unsigned nw, share, lo, hi, rem, len, src;
    bit          found;
    g     = '0;
    nw    = active_workers();
    rem   = 0;
    src   = 0;
    found = 1'b0;
    if (op == OP_BEGIN) begin
      share = (32'(total_cfg) + nw - 1) / nw;
      foreach (left_in_block[w]) begin
        left_in_block[w] = '0;
        block_stop[w]    = '0;
      end
      for (int unsigned w = 0; w < nw; w++) begin
        lo = w * share;
        hi = (w + 1) * share;
        if (hi > total_cfg) hi = 32'(total_cfg);
        if (lo > hi) lo = hi;     // trailing workers get an empty block
        block_stop[w]    = FIELD_W'(hi);
        left_in_block[w] = FIELD_W'(hi - lo);
      end
      g.done = (total_cfg == 0);
    end else begin
      if (left_in_block[wk] != 0) begin
        src   = 32'(wk);
        rem   = 32'(left_in_block[wk]);
        found = 1'b1;
      end else begin
        // steal from the most loaded active worker, lowest index on ties
        for (int unsigned w = 0; w < nw; w++) begin
          if (left_in_block[w] > rem) begin
            rem   = 32'(left_in_block[w]);
            src   = w;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        g.done = 1'b1;
      end else begin
        len = (rem + nw - 1) / nw;
        if (len > rem) len = rem;
        g.start            = FIELD_W'(32'(block_stop[src]) - rem);
        g.length           = FIELD_W'(len);
        g.owner            = WORKER_W'(src);
        g.rem_before       = FIELD_W'(rem);
        left_in_block[src] = FIELD_W'(rem - len);
      end
    end
    pending_grants.push_back(g);
    return g;
  endfunction

  function void check_grant(grant_t got);
    grant_t want;
    if (pending_grants.size() == 0) begin
      $error("grant with none outstanding: start %0d length %0d owner %0d",
             got.start, got.length, got.owner);
      mismatches++;
      return;
    end
    want = pending_grants.pop_front();
    if (got.start !== want.start) begin
      $error("chunk_start: expected %0d, got %0d", want.start, got.start);
      mismatches++;
    end
    if (got.length !== want.length) begin
      $error("chunk_length: expected %0d, got %0d", want.length, got.length);
      mismatches++;
    end
    if (got.owner !== want.owner) begin
      $error("owner: expected %0d, got %0d", want.owner, got.owner);
      mismatches++;
    end
    if (got.rem_before !== want.rem_before) begin
      $error("owner_remaining_before: expected %0d, got %0d", want.rem_before,
             got.rem_before);
      mismatches++;
    end
    if (got.done !== want.done) begin
      $error("all_done: expected %0d, got %0d", want.done, got.done);
      mismatches++;
    end
  endfunction
endclass

module affinity_chunk_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TARGET = 1800;
  localparam int DIRECTED_MAX = 30;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  acs_in_if  req_if ();
  acs_out_if grant_if ();

  affinity_chunk_scheduler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .res_o   (grant_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  chunk_grant_book book;
  int              send_idle_pct;   // chance per cycle that the sender holds off
  int              recv_stall_pct;  // chance per cycle that the receiver stalls
  int              beats_sent;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: ready toggles at random on the falling edge per the current mode.
  initial begin
    grant_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      grant_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every grant beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && grant_if.valid && grant_if.ready) begin
      book.check_grant(grant_t'{grant_if.chunk_start, grant_if.chunk_length, grant_if.owner,
                                grant_if.owner_remaining_before, grant_if.all_done});
    end
  end

  // Hard stop; the slowest legal run is well under a tenth of this.
  initial begin
    #40ms;
    $display("affinity_chunk_scheduler_test NOT OK");
    $finish;
  end

  function automatic void set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 87;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 87;
      end
      default: begin
        send_idle_pct  = 6;
        recv_stall_pct = 6;
      end
    endcase
  endfunction

  // Mostly a worker of the active set, sometimes any index the field can carry.
  function automatic logic [WORKER_W-1:0] pick_worker();
    if ($urandom_range(99) < 80) return WORKER_W'($urandom_range(book.active_workers() - 1));
    return WORKER_W'($urandom_range(2**WORKER_W - 1));
  endfunction

  // Called at a falling edge, returns at a falling edge. valid is left high so
  // back-to-back beats need no drop in between.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [WORKER_W-1:0] wk,
                           output grant_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.worker    <= wk;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = book.note_beat(op, wk);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every owed grant has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (book.pending_grants.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write only with the block idle, then read back.
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] mask;
    wait_drained();
    apb_access(idx, 1'b1, value, readback);
    apb_access(idx, 1'b0, '0, readback);
    if (idx == REG_NUM_WORKERS) begin
      book.workers_cfg = value[CFG_NW_W-1:0];
      mask = (32'd1 << CFG_NW_W) - 1;
    end else begin
      book.total_cfg = value[CFG_TOT_W-1:0];
      mask = (32'd1 << CFG_TOT_W) - 1;
    end
    if (readback !== (value & mask)) begin
      $error("register %0d readback: expected %0h, got %0h", idx, value & mask, readback);
      book.mismatches++;
    end
  endtask

  initial begin
    grant_t      g;
    int          span;
    int          dones;
    int          phase;
    int          pick;
    logic [31:0] nw_val;
    logic [31:0] tot_val;

    book           = new();
    beats_sent     = 0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.operation = OP_BEGIN;
    req_if.worker  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    set_idle(IDLE_NONE);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // request ahead of any begin: every count is zero, so nothing to hand out
    send_beat(OP_REQUEST, 6'd0, g);
    // reset config 4 workers / 729 iterations: own take, last block, steal with tie
    send_beat(OP_BEGIN, 6'd0, g);
    send_beat(OP_REQUEST, 6'd0, g);
    send_beat(OP_REQUEST, 6'd3, g);
    send_beat(OP_REQUEST, 6'd63, g);
    // empty loop: begin reports done at once, request too
    set_register(REG_TOTAL_ITERS, 32'd0);
    send_beat(OP_BEGIN, 6'd42, g);
    send_beat(OP_REQUEST, 6'd5, g);
    // widest config
    set_register(REG_NUM_WORKERS, 32'd64);
    set_register(REG_TOTAL_ITERS, 32'd65535);
    send_beat(OP_BEGIN, 6'd63, g);
    send_beat(OP_REQUEST, 6'd63, g);
    send_beat(OP_REQUEST, 6'd0, g);
    // worker count zero acts as one; a single iteration, then done
    set_register(REG_NUM_WORKERS, 32'd0);
    set_register(REG_TOTAL_ITERS, 32'd1);
    send_beat(OP_BEGIN, 6'd0, g);
    send_beat(OP_REQUEST, 6'd0, g);
    send_beat(OP_REQUEST, 6'd0, g);
    // worker count above the slot count is clamped; most trailing blocks are empty
    set_register(REG_NUM_WORKERS, 32'd127);
    set_register(REG_TOTAL_ITERS, 32'd10);
    send_beat(OP_BEGIN, 6'd0, g);
    send_beat(OP_REQUEST, 6'd63, g);
    send_beat(OP_REQUEST, 6'd9, g);
    // worker count lowered mid-pass: requesters outside the set still get their own
    // block, counts above the new set are stranded and the pass ends early
    set_register(REG_NUM_WORKERS, 32'd8);
    set_register(REG_TOTAL_ITERS, 32'd100);
    send_beat(OP_BEGIN, 6'd0, g);
    set_register(REG_NUM_WORKERS, 32'd2);
    send_beat(OP_REQUEST, 6'd7, g);
    send_beat(OP_REQUEST, 6'd5, g);
    do send_beat(OP_REQUEST, 6'd0, g); while (!g.done);

    // ---- random part: one pass per phase, idle mode rotating ----
    phase = 0;
    while (beats_sent < ITEMS_TARGET + DIRECTED_MAX) begin
      set_idle(idle_mode_e'(phase % 4));

      pick = $urandom_range(99);
      if (pick < 8)       nw_val = 1;
      else if (pick < 16) nw_val = 64;
      else if (pick < 20) nw_val = 0;
      else if (pick < 24) nw_val = $urandom_range(127, 65);
      else if (pick < 40) nw_val = $urandom_range(63, 17);
      else                nw_val = $urandom_range(16, 2);
      pick = $urandom_range(99);
      if (pick < 8)       tot_val = 0;
      else if (pick < 14) tot_val = 65535;
      else if (pick < 20) tot_val = 1;
      else if (pick < 35) tot_val = $urandom_range(65534, 301);
      else                tot_val = $urandom_range(300, 2);
      // upper bits of pwdata carry junk the register must drop
      set_register(REG_NUM_WORKERS,
                   {16'($urandom_range(2**16 - 1)), 9'd0, nw_val[CFG_NW_W-1:0]});
      set_register(REG_TOTAL_ITERS,
                   {16'($urandom_range(2**16 - 1)), tot_val[CFG_TOT_W-1:0]});

      send_beat(OP_BEGIN, WORKER_W'($urandom_range(2**WORKER_W - 1)), g);
      span  = $urandom_range(120, 10);
      dones = 0;
      for (int i = 0; i < span && dones < 3; i++) begin
        // a stray begin now and then restarts the pass halfway
        if ($urandom_range(99) < 4)
          send_beat(OP_BEGIN, WORKER_W'($urandom_range(2**WORKER_W - 1)), g);
        else
          send_beat(OP_REQUEST, pick_worker(), g);
        if (g.done) dones++;
        if (i == span / 2 && $urandom_range(99) < 20)
          set_register(REG_NUM_WORKERS, $urandom_range(book.active_workers(), 1));
      end
      phase++;
    end

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (book.mismatches == 0) begin
      $display("affinity_chunk_scheduler_test OK");
    end else begin
      $display("affinity_chunk_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule
